// ===== rtl/uks_pkg.sv =====
`timescale 1ns / 1ps
// Package for the unique-key stack: item structs, opcode and status codes, defaults.
// No dependencies; imported by uks_store, unique_key_stack_unit and its bench.
package uks_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_W         = 32;
    localparam int COUNT_W       = 5;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [KEY_W-1:0]  push_key;
        logic signed [KEY_W-1:0]  push_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [KEY_W-1:0]  out_key;
        logic signed [KEY_W-1:0]  out_value;
        logic [COUNT_W-1:0]       entry_count;
        logic                     empty_flag;
    } t_out_item;

    // Memory access strobes from the sequencer to the pair store
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctrl;

endpackage

// ===== rtl/unique_key_stack_unit.sv =====
`timescale 1ns / 1ps
// Unique-key stack: LIFO of key/value pairs that refuses a push whose key is stored.
// Depends on uks_pkg and uks_store.
// From input transfer to result valid: a push scans the store one key per cycle
// through its read port, stopping at a stored duplicate, then finishes; pop and peek
// make one store read; full, empty and unused-opcode cases go straight to finishing.
// One item at a time: the next is taken only once the last result is in the output register.
// Reset (synchronous, active low) empties the stack; the pair store is not cleared.
module unique_key_stack_unit #(
    parameter int DEPTH = uks_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  uks_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output uks_pkg::t_out_item o_out_item
);
    import uks_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    t_in_item                r_item, n_item;
    logic [FW-1:0]           r_fill, n_fill;
    logic [FW-1:0]           r_issue, n_issue;
    logic                    r_pend, n_pend;
    logic [1:0]              r_status, n_status;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic signed [KEY_W-1:0] r_value, n_value;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;

    t_mem_ctrl               w_ctrl;
    logic [AW-1:0]           w_raddr;
    logic signed [KEY_W-1:0] w_rd_key;
    logic signed [KEY_W-1:0] w_rd_value;
    logic                    w_match;
    logic                    w_in_xfer;
    logic                    w_load_out;

    // Pair store; every write lands after the scan of the same push, and the next
    // item is taken only after the finishing cycle, so reads never see a write in flight.
    uks_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .i_waddr    (r_fill[AW-1:0]),
        .i_wkey     (r_item.push_key),
        .i_wvalue   (r_item.push_value),
        .i_raddr    (w_raddr),
        .i_cmp_key  (r_item.push_key),
        .o_rd_key   (w_rd_key),
        .o_rd_value (w_rd_value),
        .o_match    (w_match)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    // Hand the finished result to the output register once it is free or draining
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_fill   = r_fill;
        n_issue  = r_issue;
        n_pend   = r_pend;
        n_status = r_status;
        n_key    = r_key;
        n_value  = r_value;
        w_ctrl   = '0;
        w_raddr  = r_issue[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_item   = i_in_item;
                    n_status = ST_OK;
                    n_key    = '0;
                    n_value  = '0;
                    n_issue  = '0;
                    n_pend   = 1'b0;
                    n_state  = S_DONE;
                    case (i_in_item.opcode)
                        OP_PUSH: begin
                            if (r_fill >= FW'(DEPTH)) begin
                                n_status = ST_OVER;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (r_fill == '0) begin
                                n_status = ST_UNDER;
                            end else begin
                                // Fetch the top entry now; data arrives next cycle
                                w_ctrl.re = 1'b1;
                                w_raddr   = AW'(r_fill - FW'(1));
                                n_state   = S_READ;
                            end
                        end
                        default: begin
                            // unused opcode: report current state only
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Compare the key read last cycle while issuing the next read
                if (r_pend && w_match) begin
                    n_status = ST_DUP;
                    n_state  = S_DONE;
                end else if (r_issue < r_fill) begin
                    w_ctrl.re = 1'b1;
                    n_issue   = r_issue + FW'(1);
                    n_pend    = 1'b1;
                end else begin
                    // No stored key matched: push on top
                    w_ctrl.we = 1'b1;
                    n_fill    = r_fill + FW'(1);
                    n_state   = S_DONE;
                end
            end
            S_READ: begin
                n_key   = w_rd_key;
                n_value = w_rd_value;
                if (r_item.opcode == OP_POP) begin
                    n_fill = r_fill - FW'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: load on finish, drop after the transfer
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_load_out) begin
            n_out_valid       = 1'b1;
            n_out.status      = r_status;
            n_out.out_key     = r_key;
            n_out.out_value   = r_value;
            n_out.entry_count = COUNT_W'(r_fill);
            n_out.empty_flag  = (r_fill == '0);
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_issue  <= n_issue;
        r_status <= n_status;
        r_key    <= n_key;
        r_value  <= n_value;
        r_out    <= n_out;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill level beyond depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_issue <= r_fill))
        else $error("scan index passed fill level");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.we |-> (r_fill < FW'(DEPTH)))
        else $error("store write with stack full");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result dropped");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |=> $stable(r_fill))
        else $error("fill level changed outside scan or read");
`endif

endmodule

// ===== rtl/uks_store.sv =====
`timescale 1ns / 1ps
// Key/value pair memory with one write and one registered read port, plus key compare.
// Depends on uks_pkg.
module uks_store #(
    parameter int DEPTH = uks_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                               i_clk,
    input  uks_pkg::t_mem_ctrl                 i_ctrl,
    input  logic [AW-1:0]                      i_waddr,
    input  logic signed [uks_pkg::KEY_W-1:0]   i_wkey,
    input  logic signed [uks_pkg::KEY_W-1:0]   i_wvalue,
    input  logic [AW-1:0]                      i_raddr,
    input  logic signed [uks_pkg::KEY_W-1:0]   i_cmp_key,
    output logic signed [uks_pkg::KEY_W-1:0]   o_rd_key,
    output logic signed [uks_pkg::KEY_W-1:0]   o_rd_value,
    output logic                               o_match
);
    import uks_pkg::*;

    logic [2*KEY_W-1:0] r_mem [DEPTH];
    logic [2*KEY_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we) begin
            r_mem[i_waddr] <= {i_wkey, i_wvalue};
        end
        if (i_ctrl.re) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    assign o_rd_key   = r_rd[2*KEY_W-1:KEY_W];
    assign o_rd_value = r_rd[KEY_W-1:0];
    assign o_match    = (r_rd[2*KEY_W-1:KEY_W] == i_cmp_key);

endmodule

// ===== dv/unique_key_stack_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for unique_key_stack_unit: directed corner cases, then random push/pop/peek
// traffic under four sender/receiver idle mixes, predicted by a scoreboard class.
// Depends on uks_pkg and the RTL of unique_key_stack_unit.
module unique_key_stack_unit_test;
    import uks_pkg::*;

    localparam int          STACK_DEPTH  = DEPTH_DEFAULT;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int unsigned LIMIT_CYCLES = 400_000;
    // Longest push scans every stored key, so the drain after the last result outlasts two such pushes.
    localparam int unsigned DRAIN_CYCLES = 2 * (STACK_DEPTH + 2) + 8;
    localparam int unsigned RANDOM_PER_PHASE = 420;

    // Predicts one result per input transfer and checks results in arrival order.
    class stack_scoreboard;
        logic signed [KEY_W-1:0] key_mem [STACK_DEPTH];
        logic signed [KEY_W-1:0] val_mem [STACK_DEPTH];
        int unsigned             level;
        t_out_item               expected_q [$];
        int unsigned             fail_count;

        function new();
            level      = 0;
            fail_count = 0;
        endfunction

        function void note_transfer(t_in_item it);
            t_out_item want;
            bit        found;
            want        = '0;
            want.status = ST_OK;
            found       = 1'b0;
            case (it.opcode)
                OP_PUSH: begin
                    // Full wins over duplicate
                    if (level >= STACK_DEPTH) begin
                        want.status = ST_OVER;
                    end else begin
                        for (int unsigned i = 0; i < level; i++)
                            if (key_mem[i] == it.push_key) found = 1'b1;
                        if (found) begin
                            want.status = ST_DUP;
                        end else begin
                            key_mem[level] = it.push_key;
                            val_mem[level] = it.push_value;
                            level++;
                        end
                    end
                end
                OP_POP, OP_PEEK: begin
                    if (level == 0) begin
                        want.status = ST_UNDER;
                    end else begin
                        want.out_key   = key_mem[level-1];
                        want.out_value = val_mem[level-1];
                        if (it.opcode == OP_POP) level--;
                    end
                end
                default: ;
            endcase
            want.entry_count = COUNT_W'(level);
            want.empty_flag  = (level == 0);
            expected_q.push_back(want);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                $error("result with no transfer pending: status %0d key %0d", got.status,
                       got.out_key);
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                fail_count++;
            end
            if (got.out_key !== want.out_key) begin
                $error("out_key mismatch: expected %0d, actual %0d", want.out_key, got.out_key);
                fail_count++;
            end
            if (got.out_value !== want.out_value) begin
                $error("out_value mismatch: expected %0d, actual %0d", want.out_value,
                       got.out_value);
                fail_count++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count mismatch: expected %0d, actual %0d", want.entry_count,
                       got.entry_count);
                fail_count++;
            end
            if (got.empty_flag !== want.empty_flag) begin
                $error("empty_flag mismatch: expected %0d, actual %0d", want.empty_flag,
                       got.empty_flag);
                fail_count++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    stack_scoreboard sb = new();
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     cycle_count    = 0;

    unique_key_stack_unit #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: give up well past the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: stall at the rate of the current phase, one fresh decision per cycle.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitors: sample handshakes at the edge, so pre-edge values are what count.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_transfer(i_in_item);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
    end

    function automatic t_in_item make_item(logic [1:0] op, logic signed [KEY_W-1:0] key,
                                           logic signed [KEY_W-1:0] value);
        t_in_item it;
        it.opcode     = op;
        it.push_key   = key;
        it.push_value = value;
        return it;
    endfunction

    // Present one item and hold it until the transfer. Call at a rising edge.
    task automatic send_item(input t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Corner cases: empty stack, extreme keys and values, duplicate, fill to the top,
    // overflow ahead of the duplicate check, unused opcode.
    task automatic run_directed();
        logic signed [KEY_W-1:0] k_min;
        logic signed [KEY_W-1:0] k_max;
        k_min = {1'b1, {(KEY_W-1){1'b0}}};
        k_max = {1'b0, {(KEY_W-1){1'b1}}};
        send_item(make_item(OP_POP,    k_max, k_min));
        send_item(make_item(OP_PEEK,   k_min, k_max));
        send_item(make_item(OP_UNUSED, '1,    '1));
        send_item(make_item(OP_PUSH,   k_min, k_max));
        send_item(make_item(OP_PUSH,   k_max, k_min));
        send_item(make_item(OP_PUSH,   k_min, 32'sd7));
        send_item(make_item(OP_PEEK,   '0,    '0));
        send_item(make_item(OP_PUSH,   32'sd0,  '1));
        send_item(make_item(OP_PUSH,   -32'sd1, '0));
        send_item(make_item(OP_PUSH,   32'sd1,  32'sd1));
        // Fill the rest of the stack with fresh keys
        for (int i = 5; i < STACK_DEPTH; i++)
            send_item(make_item(OP_PUSH, 32'sh1000 + i, $urandom));
        send_item(make_item(OP_PUSH,   32'sh0bad, $urandom));
        send_item(make_item(OP_PUSH,   k_max,     $urandom));
        send_item(make_item(OP_UNUSED, $urandom,  $urandom));
        send_item(make_item(OP_POP,    $urandom,  $urandom));
    endtask

    // Random traffic in bursts that lean toward filling, draining or neither, so both
    // the full and the empty stack come up often. Push keys hit stored or small values half
    // the time to make duplicates common; the rest are full-range.
    task automatic run_random(input int unsigned n_items);
        t_in_item    it;
        int unsigned push_pct;
        int unsigned roll;
        push_pct = 50;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i % 24 == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 85;
                    1:       push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            it.push_key   = $urandom;
            it.push_value = $urandom;
            roll = $urandom_range(99);
            if (roll < 3)             it.opcode = OP_UNUSED;
            else if (roll < push_pct) it.opcode = OP_PUSH;
            else if (roll < push_pct + (100 - push_pct) * 7 / 10) it.opcode = OP_POP;
            else                      it.opcode = OP_PEEK;
            if (it.opcode == OP_PUSH) begin
                roll = $urandom_range(99);
                if (roll < 30 && sb.level > 0)
                    it.push_key = sb.key_mem[$urandom_range(sb.level - 1)];
                else if (roll < 50)
                    it.push_key = $signed($urandom_range(15)) - 8;
            end
            send_item(it);
        end
    endtask

    initial begin
        // Hold reset low from the start, then release it.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No idling on either side
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_directed();
        run_random(RANDOM_PER_PHASE);

        // Sender idle most of the time
        send_idle_pct  = 60;
        recv_stall_pct = 0;
        run_random(RANDOM_PER_PHASE);

        // Receiver stalls most of the time
        send_idle_pct  = 0;
        recv_stall_pct = 60;
        run_random(RANDOM_PER_PHASE);

        // Both sides idle a third of the time
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        run_random(RANDOM_PER_PHASE);

        // Drop valid, let the monitor log the last transfer, wait for every predicted
        // result, then watch for strays.
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== unique_key_stack_unit.f =====
rtl/uks_pkg.sv
rtl/uks_store.sv
rtl/unique_key_stack_unit.sv
dv/unique_key_stack_unit_test.sv
